### design/pba_pkg.sv
// Shared types, field widths and helper functions of the paged bump allocator.
package pba_pkg;

	localparam int SizeW   = 17;
	localparam int AlignW  = 4;
	localparam int PageW   = 21;
	localparam int OffOutW = 20;
	localparam int IdxOutW = 4;
	localparam int SumW    = 25;

	typedef enum logic [0:0] {
		REQ_ALLOC  = 1'b0,
		REQ_REWIND = 1'b1
	} req_t;

	typedef enum logic [0:0] {
		STS_DONE    = 1'b0,
		STS_REFUSED = 1'b1
	} status_t;

	typedef struct packed {
		req_t              req_type;
		logic [SizeW-1:0]  size_bytes;
		logic [AlignW-1:0] align_log2;
	} req_item_t;

	typedef struct packed {
		status_t            status;
		logic [IdxOutW-1:0] page_index;
		logic [OffOutW-1:0] offset;
		logic [SumW-1:0]    used_bytes;
		logic [SumW-1:0]    capacity_bytes;
	} rsp_item_t;

	function automatic logic [SumW-1:0] sat_sum(input logic [SumW:0] v);
		sat_sum = v[SumW] ? {SumW{1'b1}} : v[SumW-1:0];
	endfunction

endpackage

### design/pba_cap_mem.sv
// Page capacity memory with one write port and two registered read ports.
module pba_cap_mem #(
	parameter int AW = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [pba_pkg::PageW-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr_a,
	input  logic [AW-1:0]            rd_addr_b,
	output logic [pba_pkg::PageW-1:0] rd_data_a,
	output logic [pba_pkg::PageW-1:0] rd_data_b
);
	import pba_pkg::*;

	logic [PageW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

### design/pba_core.sv
// Allocation sequencer: frame state, page table lookup, update and result register.
module pba_core #(
	parameter int MAX_PAGES         = 16,
	parameter int MAX_ALIGN_LOG2    = 12,
	parameter int MAX_REQUEST_BYTES = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [pba_pkg::PageW-1:0] page_size,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  pba_pkg::req_item_t        in_item,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output pba_pkg::rsp_item_t        rsp_item
);
	import pba_pkg::*;

	localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CW = $clog2(MAX_PAGES + 1);
	localparam logic [PageW-1:0]  MaxReq = PageW'(MAX_REQUEST_BYTES);
	localparam logic [AlignW-1:0] MaxAl  =
		(MAX_ALIGN_LOG2 > 15) ? AlignW'(15) : AlignW'(MAX_ALIGN_LOG2);
	localparam logic [CW:0] MaxPg = (CW+1)'(MAX_PAGES);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} fsm_t;

	fsm_t              state_q;
	req_item_t         req_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     cur_q;
	logic [PageW-1:0]  off_q;
	logic [SumW-1:0]   bbc_q;
	logic [SumW-1:0]   total_q;
	logic [PageW-1:0]  cap0_q;
	status_t           res_status_q;
	logic [IdxOutW-1:0] res_page_q;
	logic [OffOutW-1:0] res_off_q;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	logic              accept;
	logic              load;
	logic [PageW-1:0]  rd_a;
	logic [PageW-1:0]  rd_b;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;

	logic              lazy;
	logic [PageW-1:0]  sz;
	logic [AlignW-1:0] al;
	logic [15:0]       amask;
	logic [PageW-1:0]  off;
	logic [PageW:0]    aligned;
	logic [PageW-1:0]  cap_cur;
	logic              fit;
	logic [PageW:0]    needed;
	logic [CW:0]       nxt;
	logic [CW-1:0]     vcount;
	logic              advance;
	logic              refuse;
	logic [PageW:0]    newcap;
	logic [SumW-1:0]   vtotal;
	logic [SumW-1:0]   adv_bbc;
	logic [SumW-1:0]   app_total;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign load      = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	always_comb begin
		lazy    = (count_q == '0);
		sz      = ({4'b0, req_q.size_bytes} > MaxReq) ? MaxReq : {4'b0, req_q.size_bytes};
		al      = (req_q.align_log2 > MaxAl) ? MaxAl : req_q.align_log2;
		amask   = (16'd1 << al) - 16'd1;
		off     = lazy ? '0 : off_q;
		aligned = ({1'b0, off} + {6'b0, amask}) & ~{6'b0, amask};
		cap_cur = lazy ? page_size : ((cur_q == '0) ? cap0_q : rd_a);
		fit     = ({1'b0, aligned} + {2'b0, sz}) <= {2'b0, cap_cur};
		needed  = {1'b0, sz} + {6'b0, amask};
		nxt     = (CW+1)'(cur_q) + 1'b1;
		vcount  = lazy ? CW'(1) : count_q;
		advance = (nxt < {1'b0, vcount}) && (nxt < MaxPg) && (needed <= {1'b0, rd_b});
		refuse  = ({1'b0, vcount} >= MaxPg);
		newcap  = ({1'b0, page_size} > needed) ? {1'b0, page_size} : needed;
		vtotal  = lazy ? SumW'(page_size) : total_q;
		adv_bbc = sat_sum({1'b0, bbc_q} + (SumW+1)'(cap_cur));
		app_total = sat_sum({1'b0, vtotal} + (SumW+1)'(newcap));
		mem_we  = (state_q == S_EXEC) && (req_q.req_type == REQ_ALLOC) && !fit
			&& !advance && !refuse;
		mem_wa  = AW'(vcount);
	end

	pba_cap_mem #(.AW(AW)) u_mem (
		.clk       (clk),
		.wr_en     (mem_we),
		.wr_addr   (mem_wa),
		.wr_data   (newcap[PageW-1:0]),
		.rd_en     (accept),
		.rd_addr_a (cur_q),
		.rd_addr_b (nxt[AW-1:0]),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cur_q       <= '0;
			off_q       <= '0;
			bbc_q       <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					if (req_q.req_type == REQ_REWIND) begin
						cur_q <= '0;
						off_q <= '0;
						bbc_q <= '0;
					end else if (fit) begin
						if (lazy) begin
							count_q <= CW'(1);
							total_q <= vtotal;
							cur_q   <= '0;
							bbc_q   <= '0;
						end
						off_q <= aligned[PageW-1:0] + sz;
					end else if (advance) begin
						bbc_q <= adv_bbc;
						cur_q <= nxt[AW-1:0];
						off_q <= sz;
					end else if (!refuse) begin
						bbc_q   <= vtotal;
						total_q <= app_total;
						cur_q   <= AW'(vcount);
						count_q <= vcount + 1'b1;
						off_q   <= sz;
					end
				end
				S_RESP: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_item;
		end
		if (state_q == S_EXEC) begin
			if (req_q.req_type == REQ_ALLOC && lazy && (fit || (!advance && !refuse))) begin
				cap0_q <= page_size;
			end
			if (req_q.req_type == REQ_ALLOC && fit) begin
				res_status_q <= STS_DONE;
				res_page_q   <= IdxOutW'(cur_q);
				res_off_q    <= aligned[OffOutW-1:0];
			end else if (req_q.req_type == REQ_ALLOC && advance) begin
				res_status_q <= STS_DONE;
				res_page_q   <= IdxOutW'(nxt);
				res_off_q    <= '0;
			end else if (req_q.req_type == REQ_ALLOC && !refuse) begin
				res_status_q <= STS_DONE;
				res_page_q   <= IdxOutW'(vcount);
				res_off_q    <= '0;
			end else if (req_q.req_type == REQ_ALLOC) begin
				res_status_q <= STS_REFUSED;
				res_page_q   <= '0;
				res_off_q    <= '0;
			end else begin
				res_status_q <= STS_DONE;
				res_page_q   <= '0;
				res_off_q    <= '0;
			end
		end
		if (load) begin
			rsp_q.status         <= res_status_q;
			rsp_q.page_index     <= res_page_q;
			rsp_q.offset         <= res_off_q;
			rsp_q.used_bytes     <= sat_sum({1'b0, bbc_q} + (SumW+1)'(off_q));
			rsp_q.capacity_bytes <= total_q;
		end
	end

endmodule

### design/paged_bump_allocator.sv
// Top level of the paged bump allocator: register port, stream ports and core.
//
// Usage: configure page_size over the APB-style port (byte address 0) while idle;
// it resets to 4096. Requests arrive on the s_axis stream: tuser selects
// allocate (0) or frame rewind (1), tdata carries the size and the alignment
// exponent. Every request yields exactly one result transaction on m_axis:
// tuser is the status (1 when no page slot is left), tdata carries the page
// index, the aligned offset, the bytes used and the total capacity.
// The page capacity memory is read at the accepting edge, the execute state
// updates the frame state and the response state loads the output register.
// The sequencer returns to idle only after loading the result, so the block
// takes no new request until the previous result is in the output register.
// A result waiting in the output register does not hold off the next request;
// only a second result held behind a stalled receiver stops the sequencer.
// Reset clears the frame state and page count; no pages exist until the first
// allocate creates page zero.
module paged_bump_allocator #(
	parameter int MAX_PAGES         = 16,
	parameter int MAX_ALIGN_LOG2    = 12,
	parameter int MAX_REQUEST_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // size_bytes[16:0], align_log2[20:17]
	input  logic [0:0]  s_axis_tuser,  // req_type[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // page_index[3:0], offset[23:4],
	                                   // used_bytes[48:24], capacity_bytes[73:49]
	output logic [0:0]  m_axis_tuser   // status[0]
);
	import pba_pkg::*;

	logic [PageW-1:0] page_size_q;
	req_item_t        in_item;
	rsp_item_t        rsp_item;
	logic             reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == 1'b0);
	assign prdata  = reg_hit ? {11'b0, page_size_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PageW'(4096);
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			page_size_q <= pwdata[PageW-1:0];
		end
	end

	assign in_item.req_type   = req_t'(s_axis_tuser[0]);
	assign in_item.size_bytes = s_axis_tdata[SizeW-1:0];
	assign in_item.align_log2 = s_axis_tdata[SizeW+AlignW-1:SizeW];

	pba_core #(
		.MAX_PAGES         (MAX_PAGES),
		.MAX_ALIGN_LOG2    (MAX_ALIGN_LOG2),
		.MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.page_size (page_size_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.rsp_valid (m_axis_tvalid),
		.rsp_ready (m_axis_tready),
		.rsp_item  (rsp_item)
	);

	assign m_axis_tdata = {6'b0, rsp_item.capacity_bytes, rsp_item.used_bytes,
		rsp_item.offset, rsp_item.page_index};
	assign m_axis_tuser = rsp_item.status;

endmodule

### design/pba_checker.sv
// Port-level checker for the paged bump allocator and its bind statement.
module pba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// A held result keeps its contents until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// A request occupies the sequencer, so no request is taken in the next cycle.
	a_seq_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while previous one in progress");

	// A refused allocation reports page zero at offset zero.
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:0] == 24'b0)
		else $error("refusal with nonzero page or offset");

	// The bytes in use never exceed the total capacity created.
	a_used_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[48:24] <= m_axis_tdata[73:49])
		else $error("used bytes above capacity");

endmodule

bind paged_bump_allocator pba_checker u_pba_checker (.*);
